/* rtl/fqkr_pkg.sv */
// ----------------------------------------------------------------------------
// fqkr_pkg
// Shared types and codes of the keyed-removal queue: request opcodes, result
// status codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package fqkr_pkg;

  // identifier width
  localparam int unsigned IdW = 16;

  // request opcodes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_TAKE   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture request fields
    logic match;  // compare all cells, register match vector
    logic apply;  // update queue and load the result register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_stall;  // result register full and not taken this cycle
  } sts_t;

endpackage

/* rtl/fqkr_ctrl.sv */
// ----------------------------------------------------------------------------
// fqkr_ctrl
// Request sequencer: load, match and apply steps, with overlap of the next
// load and the current apply.
// ----------------------------------------------------------------------------
module fqkr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fqkr_pkg::sts_t sts_i,
  output fqkr_pkg::cmd_t cmd_o
);

  fqkr_pkg::state_e state_q, state_d;
  logic apply_go;
  logic load;

  // handshake and command decode
  always_comb begin
    apply_go   = (state_q == fqkr_pkg::S_APPLY) && !sts_i.out_stall;
    in_ready_o = (state_q == fqkr_pkg::S_IDLE) || apply_go;
    load       = in_valid_i && in_ready_o;
    cmd_o.load  = load;
    cmd_o.match = (state_q == fqkr_pkg::S_MATCH);
    cmd_o.apply = apply_go;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fqkr_pkg::S_IDLE: begin
        if (load) state_d = fqkr_pkg::S_MATCH;
      end
      fqkr_pkg::S_MATCH: begin
        state_d = fqkr_pkg::S_APPLY;
      end
      fqkr_pkg::S_APPLY: begin
        if (apply_go) state_d = load ? fqkr_pkg::S_MATCH : fqkr_pkg::S_IDLE;
      end
      default: state_d = fqkr_pkg::S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fqkr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/fqkr_dp.sv */
// ----------------------------------------------------------------------------
// fqkr_dp
// Queue datapath: a chain of entry cells with per-cell key compare, a
// first-match prefix network, gap-closing shift and the result register.
// ----------------------------------------------------------------------------
module fqkr_dp #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fqkr_pkg::cmd_t            cmd_i,
  output fqkr_pkg::sts_t            sts_o,
  input  logic [1:0]                op_i,
  input  logic [fqkr_pkg::IdW-1:0]  proc_id_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [fqkr_pkg::IdW-1:0]  out_id_o,
  output logic [1:0]                status_o,
  output logic                      now_empty_o
);

  localparam int unsigned N   = QUEUE_DEPTH;
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LVL = $clog2(QUEUE_DEPTH);
  localparam logic [CW-1:0] FullCount = CW'(QUEUE_DEPTH);

  // request registers
  logic [1:0]               op_q;
  logic [fqkr_pkg::IdW-1:0] id_q;

  // queue state
  logic [fqkr_pkg::IdW-1:0] entry_q [N];
  logic [CW-1:0]            count_q, count_d;

  // match path
  logic [N-1:0] match_d, match_q;
  logic [N-1:0] pre [LVL+1];
  logic [N-1:0] first;
  logic [N-1:0] shift;
  logic [N-1:0] wr_sel;
  logic         hit;
  logic [fqkr_pkg::IdW-1:0] hit_val;

  // update decode
  logic do_append, do_shift;
  logic [1:0] status_d;
  logic [fqkr_pkg::IdW-1:0] out_id_d;

  // result register
  logic                     out_valid_q;
  logic [fqkr_pkg::IdW-1:0] out_id_q;
  logic [1:0]               status_q;
  logic                     now_empty_q;

  // capture request fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      id_q <= proc_id_i;
    end
  end

  // per-cell compare against the key, limited to occupied cells; a take selects the head cell
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (op_q == fqkr_pkg::OP_TAKE) begin
        match_d[i] = (i == 0) && (count_q != '0);
      end else begin
        match_d[i] = (entry_q[i] == id_q) && (CW'(i) < count_q);
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cmp
    assign wr_sel[i] = (count_q == CW'(i));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.match) match_q <= match_d;
  end

  // prefix or over the match vector, log-depth
  always_comb begin
    pre[0] = match_q;
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i < N; i++) begin
        if (i >= (1 << l)) begin
          pre[l+1][i] = pre[l][i] | pre[l][i-(1<<l)];
        end else begin
          pre[l+1][i] = pre[l][i];
        end
      end
    end
  end

  assign shift = pre[LVL];
  assign first = match_q & ~{shift[N-2:0], 1'b0};
  assign hit   = shift[N-1];

  // select the matched identifier, one-hot or per bit
  for (genvar b = 0; b < fqkr_pkg::IdW; b++) begin : g_sel
    logic [N-1:0] col;
    for (genvar i = 0; i < N; i++) begin : g_col
      assign col[i] = entry_q[i][b];
    end
    assign hit_val[b] = |(col & first);
  end

  // update decode
  always_comb begin
    do_append = 1'b0;
    do_shift  = 1'b0;
    status_d  = fqkr_pkg::ST_OK;
    out_id_d  = '0;
    count_d   = count_q;
    unique case (op_q)
      fqkr_pkg::OP_APPEND: begin
        if (count_q == FullCount) begin
          status_d = fqkr_pkg::ST_FULL;
        end else begin
          do_append = 1'b1;
          count_d   = count_q + CW'(1);
        end
      end
      fqkr_pkg::OP_TAKE, fqkr_pkg::OP_REMOVE: begin
        if (count_q == '0) begin
          status_d = fqkr_pkg::ST_EMPTY;
        end else if (hit) begin
          do_shift = 1'b1;
          out_id_d = hit_val;
          count_d  = count_q - CW'(1);
        end else begin
          status_d = fqkr_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        status_d = fqkr_pkg::ST_OK;
      end
    endcase
  end

  // entry cells: append at tail, close the gap behind the removed entry
  for (genvar i = 0; i < N; i++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (cmd_i.apply) begin
        if (do_append && wr_sel[i]) begin
          entry_q[i] <= id_q;
        end else if (do_shift && shift[i] && (i < N - 1)) begin
          entry_q[i] <= entry_q[(i < N - 1) ? i + 1 : i];
        end
      end
    end
  end

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.apply) begin
      count_q <= count_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.apply) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      out_id_q    <= out_id_d;
      status_q    <= status_d;
      now_empty_q <= (count_d == '0);
    end
  end

  assign sts_o.out_stall = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_id_o    = out_id_q;
  assign status_o    = status_q;
  assign now_empty_o = now_empty_q;

  // occupancy never exceeds the queue depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FullCount)
    else $error("occupancy above depth");

  // append on a full queue reports full and leaves occupancy alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply && (op_q == fqkr_pkg::OP_APPEND) && (count_q == FullCount)
    |=> (status_q == fqkr_pkg::ST_FULL) && (count_q == FullCount))
    else $error("append on full queue mishandled");

  // take on a non-empty queue removes exactly one entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply && (op_q == fqkr_pkg::OP_TAKE) && (count_q != '0)
    |=> (count_q == $past(count_q) - CW'(1)) && (status_q == fqkr_pkg::ST_OK))
    else $error("take did not remove the head");

  // at most one cell is selected for removal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply |-> $onehot0(first))
    else $error("more than one cell selected");

endmodule

/* rtl/fifo_queue_with_keyed_removal.sv */
// ----------------------------------------------------------------------------
// fifo_queue_with_keyed_removal
// Ordered queue of 16-bit identifiers with append, take-head and
// remove-by-key requests; one result per request.
// ----------------------------------------------------------------------------
// Each request passes through a load, a match and an apply step, and the
// next request is accepted in the current apply step: the match step
// compares the key against every cell of the entry chain at once, the apply
// step picks the oldest match, closes the gap by shifting the younger cells
// forward and loads the result register. A result that is not taken holds
// the block in its apply step, and no new request is accepted meanwhile.
// Entries are not cleared at reset; only occupied cells are compared or returned.
module fifo_queue_with_keyed_removal #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                op_i,
  input  logic [fqkr_pkg::IdW-1:0]  proc_id_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [fqkr_pkg::IdW-1:0]  out_id_o,
  output logic [1:0]                status_o,
  output logic                      now_empty_o
);

  fqkr_pkg::cmd_t cmd;
  fqkr_pkg::sts_t sts;

  // request sequencer
  fqkr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // entry chain and result register
  fqkr_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (op_i),
    .proc_id_i   (proc_id_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_id_o    (out_id_o),
    .status_o    (status_o),
    .now_empty_o (now_empty_o)
  );

endmodule
